[hdl/base64_stream_decoder_unit_defines.svh]
// assertion macros shared by the decoder modules
`ifndef BASE64_STREAM_DECODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define B64D_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define B64D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/b64d_pkg.sv]
`timescale 1ns / 1ps
package b64d_pkg;

   localparam int QueueDepth      = 4;
   localparam int QueuePtrWidth   = $clog2(QueueDepth);
   localparam int QueueCountWidth = $clog2(QueueDepth + 1);

   localparam logic [7:0] PadChar     = 8'h3D;
   localparam logic [7:0] NewlineChar = 8'h0A;

   localparam logic [1:0] KIND_SEXTET  = 2'd0;
   localparam logic [1:0] KIND_PAD     = 2'd1;
   localparam logic [1:0] KIND_NEWLINE = 2'd2;
   localparam logic [1:0] KIND_GARBAGE = 2'd3;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_INVALID    = 2'd1;
   localparam logic [1:0] STATUS_INCOMPLETE = 2'd2;

   localparam logic [0:0] REG_SKIP_INVALID = 1'b0;

   typedef struct packed {
      logic [1:0] kind;
      logic [5:0] sextet;
   } char_class_type;

   typedef struct packed {
      logic            is_status;
      logic [1:0]      status_code;
      logic [1:0]      last_idx;
      logic [2:0][7:0] bytes;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic nonempty;
   } queue_status_type;

   function automatic char_class_type classify_char(input logic [7:0] c);
      char_class_type r;
      r.kind   = KIND_GARBAGE;
      r.sextet = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r.kind   = KIND_SEXTET;
         r.sextet = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r.kind   = KIND_SEXTET;
         r.sextet = 6'(c - 8'd71);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r.kind   = KIND_SEXTET;
         r.sextet = 6'(c + 8'd4);
      end else if (c == 8'h2B) begin
         r.kind   = KIND_SEXTET;
         r.sextet = 6'd62;
      end else if (c == 8'h2F) begin
         r.kind   = KIND_SEXTET;
         r.sextet = 6'd63;
      end else if (c == PadChar) begin
         r.kind = KIND_PAD;
      end else if (c == NewlineChar) begin
         r.kind = KIND_NEWLINE;
      end
      return r;
   endfunction

endpackage

[hdl/b64d_req_if.sv]
`timescale 1ns / 1ps
interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_stream;

   modport source (output valid, output char_byte, output end_of_stream, input ready);
   modport sink (input valid, input char_byte, input end_of_stream, output ready);
endinterface

[hdl/b64d_rsp_if.sv]
`timescale 1ns / 1ps
interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_status;
   logic [7:0] data_byte;
   logic [1:0] status_code;
   logic       last_of_run;

   modport source (output valid, output is_status, output data_byte, output status_code,
                   output last_of_run, input ready);
   modport sink (input valid, input is_status, input data_byte, input status_code,
                 input last_of_run, output ready);
endinterface

[hdl/base64_stream_decoder_unit.sv]
`timescale 1ns / 1ps
// base64 stream decoder
// req_bus carries one character byte per transaction, or an end-of-stream mark.
// rsp_bus returns decoded bytes, one per transaction, and one status transaction
// per end-of-stream mark (0 ok, 1 invalid character, 2 incomplete group);
// last_of_run marks the final result caused by one request.
// csr port holds the skip_invalid flag at byte address 0; write it only while idle.
// throughput: one request per cycle while the queue is not full; results leave at
// one per cycle while rsp_bus is ready, so a group of four characters (three bytes)
// keeps pace with the input. the first result of a request passes through the
// command queue (4 entries) and then the output register before rsp_bus sees it.
// when rsp_bus stalls the queue fills and req_bus.ready drops once it is full.
// synchronous reset clears the open group, the sticky error, skip_invalid,
// the queue and the output register; no results are pending after reset.
module base64_stream_decoder_unit
   import b64d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   b64d_req_if.sink    req_bus,
   b64d_rsp_if.source  rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic             skip_invalid_ff, skip_invalid_in;
   logic             push;
   logic             pop;
   cmd_type          push_data;
   cmd_type          pop_data;
   queue_status_type q_status;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_SKIP_INVALID) ?
                       {31'd0, skip_invalid_ff} : 32'd0;

   always_comb begin
      skip_invalid_in = skip_invalid_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_SKIP_INVALID) begin
         skip_invalid_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_invalid_ff <= 1'b0;
      end else begin
         skip_invalid_ff <= skip_invalid_in;
      end
   end

   b64d_front u_front (
      .clock        (clock),
      .reset        (reset),
      .skip_invalid (skip_invalid_ff),
      .req_bus      (req_bus),
      .q_status     (q_status),
      .push         (push),
      .push_data    (push_data)
   );

   b64d_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_status  (q_status)
   );

   b64d_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule

[hdl/b64d_front.sv]
`timescale 1ns / 1ps
module b64d_front
   import b64d_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             skip_invalid,
   b64d_req_if.sink         req_bus,
   input  queue_status_type q_status,
   output logic             push,
   output cmd_type          push_data
);

   logic [2:0][5:0] slots_ff, slots_in;
   logic [1:0]      slot_count_ff, slot_count_in;
   logic [1:0]      pad_count_ff, pad_count_in;
   logic            error_ff, error_in;

   char_class_type  cls;
   logic            accept;
   logic            take;
   logic [5:0]      sext;
   logic [1:0]      pad_new;
   logic [1:0]      nbytes;

   assign req_bus.ready = !q_status.full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign cls           = classify_char(req_bus.char_byte);

   always_comb begin
      slots_in      = slots_ff;
      slot_count_in = slot_count_ff;
      pad_count_in  = pad_count_ff;
      error_in      = error_ff;
      push          = 1'b0;
      push_data     = '0;
      take          = 1'b0;
      sext          = cls.sextet;
      pad_new       = pad_count_ff;
      nbytes        = 2'd0;
      if (accept) begin
         if (req_bus.end_of_stream) begin
            push                  = 1'b1;
            push_data.is_status   = 1'b1;
            push_data.last_idx    = 2'd0;
            if (error_ff) begin
               push_data.status_code = STATUS_INVALID;
            end else if (slot_count_ff != 2'd0) begin
               push_data.status_code = STATUS_INCOMPLETE;
            end else begin
               push_data.status_code = STATUS_OK;
            end
            slot_count_in = 2'd0;
            pad_count_in  = 2'd0;
            error_in      = 1'b0;
         end else if (!error_ff) begin
            unique case (cls.kind)
               KIND_SEXTET: begin
                  take = 1'b1;
               end
               KIND_PAD: begin
                  take    = 1'b1;
                  sext    = 6'd0;
                  pad_new = (pad_count_ff == 2'd3) ? 2'd3 : pad_count_ff + 2'd1;
               end
               KIND_NEWLINE: begin
               end
               default: begin
                  if (!skip_invalid) begin
                     error_in = 1'b1;
                  end
               end
            endcase
         end
      end
      if (take) begin
         if (slot_count_ff != 2'd3) begin
            slots_in[slot_count_ff] = sext;
            slot_count_in           = slot_count_ff + 2'd1;
            pad_count_in            = pad_new;
         end else begin
            nbytes                = 2'd3 - pad_new;
            push                  = (nbytes != 2'd0);
            push_data.is_status   = 1'b0;
            push_data.status_code = STATUS_OK;
            push_data.last_idx    = nbytes - 2'd1;
            push_data.bytes[0]    = {slots_ff[0], slots_ff[1][5:4]};
            push_data.bytes[1]    = {slots_ff[1][3:0], slots_ff[2][5:2]};
            push_data.bytes[2]    = {slots_ff[2][1:0], sext};
            slot_count_in         = 2'd0;
            pad_count_in          = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
      if (reset) begin
         slot_count_ff <= 2'd0;
         pad_count_ff  <= 2'd0;
         error_ff      <= 1'b0;
      end else begin
         slot_count_ff <= slot_count_in;
         pad_count_ff  <= pad_count_in;
         error_ff      <= error_in;
      end
   end

endmodule

[hdl/b64d_cmd_queue.sv]
`timescale 1ns / 1ps
`include "base64_stream_decoder_unit_defines.svh"
module b64d_cmd_queue
   import b64d_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_data,
   input  logic             pop,
   output cmd_type          pop_data,
   output queue_status_type q_status
);

   cmd_type [QueueDepth-1:0]   entries_ff;
   logic [QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCountWidth-1:0] count_ff, count_in;

   assign q_status.full     = (count_ff == QueueCountWidth'(QueueDepth));
   assign q_status.nonempty = (count_ff != '0);
   assign pop_data          = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `B64D_ASSERT_NOW(a_no_push_full, clock, reset, push, !q_status.full || pop, "push into full queue")
   `B64D_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, q_status.nonempty, "pop from empty queue")
   `B64D_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "count did not rise")
   `B64D_ASSERT_NOW(a_ptr_gap, clock, reset, q_status.nonempty && !q_status.full, wr_ptr_ff != rd_ptr_ff, "pointer gap mismatch")

endmodule

[hdl/b64d_back.sv]
`timescale 1ns / 1ps
`include "base64_stream_decoder_unit_defines.svh"
module b64d_back
   import b64d_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  cmd_type          pop_data,
   output logic             pop,
   b64d_rsp_if.source       rsp_bus
);

   cmd_type    cur_ff, cur_in;
   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic       done;

   assign done = !valid_ff || (rsp_bus.ready && idx_ff == cur_ff.last_idx);
   assign pop  = done && q_status.nonempty;

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.is_status   = cur_ff.is_status;
   assign rsp_bus.data_byte   = cur_ff.is_status ? 8'd0 : cur_ff.bytes[idx_ff];
   assign rsp_bus.status_code = cur_ff.is_status ? cur_ff.status_code : STATUS_OK;
   assign rsp_bus.last_of_run = (idx_ff == cur_ff.last_idx);

   always_comb begin
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (done) begin
         valid_in = q_status.nonempty;
         cur_in   = pop_data;
         idx_in   = 2'd0;
      end else if (rsp_bus.ready) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   `B64D_ASSERT_NOW(a_status_single, clock, reset, valid_ff && cur_ff.is_status, cur_ff.last_idx == 2'd0, "status spans several results")
   `B64D_ASSERT_NOW(a_idx_range, clock, reset, valid_ff, idx_ff <= cur_ff.last_idx, "byte index past last")
   `B64D_ASSERT_NEXT(a_hold, clock, reset, valid_ff && !rsp_bus.ready, valid_ff && $stable(idx_ff), "stall not held")

endmodule
